FILE: rtl/core/sps_pkg.sv
package sps_pkg;

	typedef enum logic [2:0] {
		PH_REST    = 3'd0,
		PH_PROBE   = 3'd1,
		PH_SETTLE  = 3'd2,
		PH_AWAIT   = 3'd3,
		PH_OVERLAP = 3'd4,
		PH_ON      = 3'd5
	} phase_t;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ON_TIME          = 3'd0;
	localparam cfg_idx_t REG_OFF_TIME         = 3'd1;
	localparam cfg_idx_t REG_SPARK_LEVEL      = 3'd2;
	localparam cfg_idx_t REG_BREAKDOWN_WINDOW = 3'd3;
	localparam cfg_idx_t REG_READY_COUNT      = 3'd4;

	localparam logic [15:0] RST_ON_TIME          = 16'd10;
	localparam logic [15:0] RST_OFF_TIME         = 16'd100;
	localparam logic [7:0]  RST_SPARK_LEVEL      = 8'd0;
	localparam logic [15:0] RST_BREAKDOWN_WINDOW = 16'd100;
	localparam logic [3:0]  RST_READY_COUNT      = 4'd10;

	localparam logic [7:0] LVL_100 = 8'd100;
	localparam logic [7:0] LVL_150 = 8'd150;
	localparam logic [7:0] LVL_200 = 8'd200;
	localparam logic [7:0] LVL_250 = 8'd250;

	localparam logic [2:0] SEL_100 = 3'b000;
	localparam logic [2:0] SEL_150 = 3'b100;
	localparam logic [2:0] SEL_200 = 3'b010;
	localparam logic [2:0] SEL_250 = 3'b001;

	typedef struct packed {
		logic [15:0] on_time;
		logic [15:0] off_time;
		logic [7:0]  spark_level;
		logic [15:0] breakdown_window;
		logic [3:0]  ready_count;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  ready_counter;
		logic [2:0]  select_pattern;
		logic        breakdown_flag;
		logic        short_flag;
	} ctl_t;

	typedef struct packed {
		logic ready_pin;
		logic short_pin;
		logic breakdown_pin;
	} pins_t;

	typedef struct packed {
		logic       high_drive;
		logic       low_drive;
		logic [2:0] level_bits;
		logic       supply_ready;
		logic       breakdown_seen;
		logic       short_seen;
		logic [2:0] phase_code;
	} res_t;

endpackage

FILE: rtl/core/sps_pins_if.sv
interface sps_pins_if;
	logic valid;
	logic ready;
	logic ready_pin;
	logic short_pin;
	logic breakdown_pin;

	modport source (output valid, ready_pin, short_pin, breakdown_pin, input ready);
	modport sink (input valid, ready_pin, short_pin, breakdown_pin, output ready);
endinterface

FILE: rtl/core/sps_res_if.sv
interface sps_res_if;
	logic       valid;
	logic       ready;
	logic       high_drive;
	logic       low_drive;
	logic [2:0] level_bits;
	logic       supply_ready;
	logic       breakdown_seen;
	logic       short_seen;
	logic [2:0] phase_code;

	modport source (output valid, high_drive, low_drive, level_bits, supply_ready,
		breakdown_seen, short_seen, phase_code, input ready);
	modport sink (input valid, high_drive, low_drive, level_bits, supply_ready,
		breakdown_seen, short_seen, phase_code, output ready);
endinterface

FILE: rtl/core/sps_cfg_if.sv
interface sps_cfg_if
	import sps_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sps_cfg.sv
module sps_cfg
	import sps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sps_cfg_if.sink    cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.on_time          <= RST_ON_TIME;
			regs_q.off_time         <= RST_OFF_TIME;
			regs_q.spark_level      <= RST_SPARK_LEVEL;
			regs_q.breakdown_window <= RST_BREAKDOWN_WINDOW;
			regs_q.ready_count      <= RST_READY_COUNT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ON_TIME:          regs_q.on_time          <= cfg.data;
				REG_OFF_TIME:         regs_q.off_time         <= cfg.data;
				REG_SPARK_LEVEL:      regs_q.spark_level      <= cfg.data[7:0];
				REG_BREAKDOWN_WINDOW: regs_q.breakdown_window <= cfg.data;
				REG_READY_COUNT:      regs_q.ready_count      <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/sps_step.sv
module sps_step
	import sps_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  cfg_t                  cfg,
	input  ctl_t                  ctl,
	input  logic [TIMER_BITS-1:0] timer,
	input  pins_t                 pins,
	output ctl_t                  ctl_nxt,
	output logic [TIMER_BITS-1:0] timer_nxt,
	output res_t                  res
);

	localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);
	localparam logic [TIMER_BITS-1:0] T_TWO = TIMER_BITS'(2);

	// zero acts as one tick, wide values are cut to the timer width
	function automatic logic [TIMER_BITS-1:0] tload(input logic [15:0] v);
		logic [TIMER_BITS-1:0] t;
		t = TIMER_BITS'(v);
		return (t == '0) ? T_ONE : t;
	endfunction

	logic [3:0] need;
	logic       expired;

	assign need    = (cfg.ready_count == 4'd0) ? 4'd1 : cfg.ready_count;
	assign expired = (timer == '0);

	// next state
	always_comb begin
		ctl_nxt   = ctl;
		timer_nxt = timer;

		case (cfg.spark_level)
			LVL_100: ctl_nxt.select_pattern = SEL_100;
			LVL_150: ctl_nxt.select_pattern = SEL_150;
			LVL_200: ctl_nxt.select_pattern = SEL_200;
			LVL_250: ctl_nxt.select_pattern = SEL_250;
			default: ;
		endcase

		case (ctl.phase)
			PH_REST: begin
				if (!expired)
					timer_nxt = timer - T_ONE;
				if (!pins.ready_pin) begin
					ctl_nxt.ready_counter = 4'd0;
				end else begin
					if (ctl.ready_counter < need)
						ctl_nxt.ready_counter = ctl.ready_counter + 4'd1;
					if (expired && ctl_nxt.ready_counter >= need) begin
						ctl_nxt.phase = PH_PROBE;
						timer_nxt     = T_TWO;
					end else begin
						if (expired)
							timer_nxt = tload(cfg.off_time);
						ctl_nxt.short_flag = ~pins.short_pin;
					end
				end
			end
			PH_PROBE: begin
				if (timer > T_ONE) begin
					timer_nxt = timer - T_ONE;
				end else if (!pins.short_pin) begin
					ctl_nxt.phase = PH_REST;
					timer_nxt     = tload(cfg.off_time);
				end else begin
					ctl_nxt.phase = PH_SETTLE;
					timer_nxt     = T_ONE;
				end
			end
			PH_SETTLE: begin
				ctl_nxt.phase = PH_AWAIT;
				timer_nxt     = tload(cfg.breakdown_window);
			end
			PH_AWAIT: begin
				if (!pins.breakdown_pin) begin
					ctl_nxt.breakdown_flag = 1'b1;
					ctl_nxt.phase          = PH_OVERLAP;
				end else if (timer > T_ONE) begin
					timer_nxt = timer - T_ONE;
				end else begin
					ctl_nxt.breakdown_flag = 1'b0;
					ctl_nxt.phase          = PH_REST;
					timer_nxt              = tload(cfg.off_time);
				end
			end
			PH_OVERLAP: begin
				ctl_nxt.phase = PH_ON;
				timer_nxt     = tload(cfg.on_time);
			end
			PH_ON: begin
				if (timer > T_ONE) begin
					timer_nxt = timer - T_ONE;
				end else begin
					ctl_nxt.phase = PH_REST;
					timer_nxt     = tload(cfg.off_time);
				end
			end
			default: begin
				ctl_nxt.phase = PH_REST;
				timer_nxt     = tload(cfg.off_time);
			end
		endcase
	end

	// outputs from the updated state
	always_comb begin
		res.high_drive     = (ctl_nxt.phase inside {PH_PROBE, PH_SETTLE, PH_AWAIT, PH_OVERLAP});
		res.low_drive      = (ctl_nxt.phase inside {PH_OVERLAP, PH_ON});
		res.level_bits     = ctl_nxt.select_pattern;
		res.supply_ready   = (ctl_nxt.ready_counter >= need);
		res.breakdown_seen = ctl_nxt.breakdown_flag;
		res.short_seen     = ctl_nxt.short_flag;
		res.phase_code     = ctl_nxt.phase;
	end

endmodule

FILE: rtl/core/spark_pulse_sequencer.sv
// a tick's result passes the input register, then the state update into the
// result register; either stage holds it while the result is not taken
// throughput: one item per cycle unless stalled; one state update per tick
// reset: asynchronous, active low; phase rest with off time expired, counters
// and flags cleared, registers at their defaults, no result pending
module spark_pulse_sequencer
	import sps_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sps_pins_if.sink    pins,
	sps_res_if.source   result,
	sps_cfg_if.sink     cfg
);

	cfg_t                  regs;
	pins_t                 pins_s1;
	logic                  s1_valid_q;
	ctl_t                  ctl_q;
	ctl_t                  ctl_nxt;
	logic [TIMER_BITS-1:0] timer_q;
	logic [TIMER_BITS-1:0] timer_nxt;
	res_t                  res;
	res_t                  res_q;
	logic                  out_valid_q;
	logic                  load_out;
	logic                  advance;

	sps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sps_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.cfg       (regs),
		.ctl       (ctl_q),
		.timer     (timer_q),
		.pins      (pins_s1),
		.ctl_nxt   (ctl_nxt),
		.timer_nxt (timer_nxt),
		.res       (res)
	);

	assign load_out   = !out_valid_q || result.ready;
	assign advance    = s1_valid_q && load_out;
	assign pins.ready = !s1_valid_q || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pins.ready) begin
			s1_valid_q <= pins.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pins.valid && pins.ready) begin
			pins_s1.ready_pin     <= pins.ready_pin;
			pins_s1.short_pin     <= pins.short_pin;
			pins_s1.breakdown_pin <= pins.breakdown_pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase          <= PH_REST;
			ctl_q.ready_counter  <= 4'd0;
			ctl_q.select_pattern <= SEL_100;
			ctl_q.breakdown_flag <= 1'b0;
			ctl_q.short_flag     <= 1'b0;
			timer_q              <= '0;
			out_valid_q          <= 1'b0;
		end else begin
			if (advance) begin
				ctl_q   <= ctl_nxt;
				timer_q <= timer_nxt;
			end
			if (load_out)
				out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign result.valid          = out_valid_q;
	assign result.high_drive     = res_q.high_drive;
	assign result.low_drive      = res_q.low_drive;
	assign result.level_bits     = res_q.level_bits;
	assign result.supply_ready   = res_q.supply_ready;
	assign result.breakdown_seen = res_q.breakdown_seen;
	assign result.short_seen     = res_q.short_seen;
	assign result.phase_code     = res_q.phase_code;

	// both drives together only in the overlap tick
	a_overlap_only: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.high_drive && result.low_drive
		|-> result.phase_code == PH_OVERLAP)
		else $error("both drives on outside overlap");

	// while in probe the timer is never zero and never above two
	a_probe_timer: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase == PH_PROBE |-> (timer_q != '0 && timer_q <= TIMER_BITS'(2)))
		else $error("probe timer out of range");

	// a held input item is not dropped while the result stage is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !load_out |=> s1_valid_q && $stable(pins_s1))
		else $error("input stage lost a stalled item");

endmodule
